// ===== sv/fsjs_pkg.sv =====
// ----------------------------------------------------------------------------
// fsjs_pkg
// Shared widths, limits and types of the fixed-start job schedule core.
// ----------------------------------------------------------------------------
package fsjs_pkg;

  localparam int unsigned DUR_W            = 6;
  localparam int unsigned PAY_W            = 16;
  localparam int unsigned TOTAL_W          = 40;
  localparam int unsigned DEF_MAX_DURATION = 63;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [DUR_W-1:0]   dur_t;
  typedef logic [PAY_W-1:0]   pay_t;

  localparam total_t TOTAL_MAX = {TOTAL_W{1'b1}};

  // Registered view of one window read port with its bypass
  typedef struct packed {
    logic   byp;     // take byp_data instead of the memory word
    total_t byp_data;
    logic   vld;     // entry written since last clear
  } rd_port_t;

endpackage

// ===== sv/fixed_start_job_schedule_dp_core.sv =====
// Flow: an accepted item is registered into the update stage (item fields and
// window reads), which updates the window and, for a last_day item, pushes the best total to the master side.
// Throughput: one item per cycle while the result buffer has room, with a bypassed
// read/modify/write of the offer window memory (two read ports, one write port).
// Output: two-entry result buffer; input stalls only if two would wait after the edge.
// Reset: clears best, pointer, valid bits and result buffer at once; no clearing pass.
// ----------------------------------------------------------------------------
// fixed_start_job_schedule_dp_core
// Weighted job scheduling with fixed start days, one day per item, keeping
// the pending offers of the coming days in a circular window memory.
// ----------------------------------------------------------------------------
module fixed_start_job_schedule_dp_core #(
  parameter int unsigned MAX_DURATION = fsjs_pkg::DEF_MAX_DURATION
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [5:0] duration, [21:6] pay, [23:22] zero
  input  logic [fsjs_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // last_day
  input  logic                           s_axis_tlast_i,
  // master side
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [39:0] best_total
  output logic [fsjs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import fsjs_pkg::*;

  localparam int unsigned Win  = MAX_DURATION + 1;
  localparam int unsigned AW   = $clog2(Win);
  localparam int unsigned SumW = ((AW > DUR_W) ? AW : DUR_W) + 1;

  typedef logic [AW-1:0] slot_t;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  total_t            win_mem [Win];
  logic [Win-1:0]    vld_q, vld_d;
  total_t            mem_a_q, mem_b_q;
  rd_port_t          rd_a_q, rd_a_d, rd_b_q, rd_b_d;

  slot_t             cur_q, cur_d;
  total_t            best_q, best_d;
  total_t            here_q, here_d;

  logic              s1_vld_q;
  logic              s1_last_q;
  logic              s1_dur_ok_q;
  pay_t              s1_pay_q;
  slot_t             s1_cur_q, s1_tgt_q, s1_nxt_q;

  logic              in_acc;
  dur_t              in_dur;
  pay_t              in_pay;
  logic              in_dur_ok;
  logic [SumW-1:0]   tgt_sum;
  slot_t             in_tgt, in_nxt;

  total_t            tgt_old, nxt_old, nxt_new;
  total_t            best_new, offer, wr_data, result;
  logic [TOTAL_W:0]  offer_sum;
  logic              wr_en;

  total_t            ent0_q, ent1_q;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;

  // --------------------------------------------------------------------------
  // Accept side: unpack item and form window addresses
  // --------------------------------------------------------------------------
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign in_dur = s_axis_tdata_i[DUR_W-1:0];
  assign in_pay = s_axis_tdata_i[DUR_W+PAY_W-1:DUR_W];

  assign in_dur_ok = (in_dur != '0) && (SumW'(in_dur) <= SumW'(MAX_DURATION));

  always_comb begin
    tgt_sum = SumW'(cur_q) + SumW'(in_dur);
    if (tgt_sum >= SumW'(Win)) begin
      tgt_sum = tgt_sum - SumW'(Win);
    end
    // park an unused target on the current slot to keep it in range
    in_tgt = in_dur_ok ? tgt_sum[AW-1:0] : cur_q;
    in_nxt = (cur_q == slot_t'(Win - 1)) ? '0 : cur_q + slot_t'(1);
  end

  // Advance the day pointer; a last day restarts the window at slot zero
  assign cur_d = in_acc ? (s_axis_tlast_i ? '0 : in_nxt) : cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      s1_vld_q <= in_acc;
    end
  end

  // Hold item fields for the update stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_last_q   <= s_axis_tlast_i;
      s1_dur_ok_q <= in_dur_ok;
      s1_pay_q    <= in_pay;
      s1_cur_q    <= cur_q;
      s1_tgt_q    <= in_tgt;
      s1_nxt_q    <= in_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Window reads with bypass of the update retiring at the same edge
  // --------------------------------------------------------------------------
  always_comb begin
    rd_a_d = '{byp: 1'b0, byp_data: '0, vld: vld_q[in_tgt]};
    if (s1_vld_q && s1_last_q) begin
      rd_a_d.byp = 1'b1;
    end else if (wr_en && (in_tgt == s1_tgt_q)) begin
      rd_a_d.byp      = 1'b1;
      rd_a_d.byp_data = wr_data;
    end else if (s1_vld_q && (in_tgt == s1_cur_q)) begin
      rd_a_d.byp = 1'b1;
    end

    rd_b_d = '{byp: 1'b0, byp_data: '0, vld: vld_q[in_nxt]};
    if (s1_vld_q && s1_last_q) begin
      rd_b_d.byp = 1'b1;
    end else if (wr_en && (in_nxt == s1_tgt_q)) begin
      rd_b_d.byp      = 1'b1;
      rd_b_d.byp_data = wr_data;
    end else if (s1_vld_q && (in_nxt == s1_cur_q)) begin
      rd_b_d.byp = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_a_q <= win_mem[in_tgt];
    mem_b_q <= win_mem[in_nxt];
    rd_a_q  <= rd_a_d;
    rd_b_q  <= rd_b_d;
  end

  assign tgt_old = rd_a_q.byp ? rd_a_q.byp_data : (rd_a_q.vld ? mem_a_q : '0);
  assign nxt_old = rd_b_q.byp ? rd_b_q.byp_data : (rd_b_q.vld ? mem_b_q : '0);

  // --------------------------------------------------------------------------
  // Update stage: fold today's offer, raise the target day's offer
  // --------------------------------------------------------------------------
  always_comb begin
    best_new  = (here_q > best_q) ? here_q : best_q;
    offer_sum = {1'b0, best_new} + (TOTAL_W + 1)'(s1_pay_q);
    offer     = offer_sum[TOTAL_W] ? TOTAL_MAX : offer_sum[TOTAL_W-1:0];
    wr_data   = (offer > tgt_old) ? offer : tgt_old;
    wr_en     = s1_vld_q && s1_dur_ok_q && !s1_last_q;
    nxt_new   = (s1_dur_ok_q && (s1_tgt_q == s1_nxt_q)) ? wr_data : nxt_old;
    result    = (nxt_new > best_new) ? nxt_new : best_new;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[s1_tgt_q] <= wr_data;
    end
  end

  // Drop today's slot, mark the written one; a last day drops them all
  always_comb begin
    vld_d = vld_q;
    if (s1_vld_q) begin
      if (s1_last_q) begin
        vld_d = '0;
      end else begin
        vld_d[s1_cur_q] = 1'b0;
        if (wr_en) begin
          vld_d[s1_tgt_q] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    best_d = best_q;
    here_d = here_q;
    if (s1_vld_q) begin
      best_d = s1_last_q ? '0 : best_new;
      here_d = s1_last_q ? '0 : nxt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      best_q <= '0;
      here_q <= '0;
    end else begin
      vld_q  <= vld_d;
      best_q <= best_d;
      here_q <= here_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer, two entries
  // --------------------------------------------------------------------------
  assign push  = s1_vld_q && s1_last_q;
  assign pop   = m_axis_tvalid_o && m_axis_tready_i;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == 2'd2) begin
        ent0_q <= ent1_q;
        if (push) begin
          ent1_q <= result;
        end
      end else if (push) begin
        ent0_q <= result;
      end
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        ent0_q <= result;
      end else begin
        ent1_q <= result;
      end
    end
  end

  // Accept only while at most one result stays buffered after this edge
  assign s_axis_tready_o = (cnt_d <= 2'd1);
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = ent0_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != 2'd2) || pop)
    else $error("result buffer overflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_tgt_not_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> s1_tgt_q != s1_cur_q)
    else $error("offer written into the current day slot");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (best_q == '0) && (here_q == '0) && (vld_q == '0))
    else $error("state not cleared after last day");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SumW'(cur_q) < SumW'(Win)))
    else $error("day pointer beyond window");

endmodule
